// ===== sv/batch_sample_statistics_defines.svh =====
// ----------------------------------------------------------------------------
// Batch sample statistics: assertion macros
// Shared property forms for the port checker, sampled on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef BATCH_SAMPLE_STATISTICS_DEFINES_SVH
`define BATCH_SAMPLE_STATISTICS_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BSS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg
// Widths, register indexes, reset values and shared types of the batch
// sample statistics block.
// ----------------------------------------------------------------------------
package bss_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int CNT_W           = 5;
   localparam int SUM_W           = SAMPLE_W + CNT_W;
   localparam int DIV_STEPS       = SAMPLE_W / 2;
   localparam int DIV_CNT_W       = $clog2(DIV_STEPS);
   localparam int STORE_DEPTH_DEF = 16;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_LEN   = 2'd2;

   localparam logic [SAMPLE_W-1:0] ACCEPT_LOW_RST  = 16'h0000;
   localparam logic [SAMPLE_W-1:0] ACCEPT_HIGH_RST = 16'hFFFF;
   localparam logic [CNT_W-1:0]    BATCH_LEN_RST   = 5'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_DIV_MEAN,
      ST_DIV_TRIM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic insert;
      logic load;
      logic shift;
      logic occupied;
      logic tail;
   } cell_ctl_type;

endpackage

// ===== sv/bss_cell.sv =====
// ----------------------------------------------------------------------------
// bss_cell
// One slot of the sorted sample row plus one stage of the readout chain.
// ----------------------------------------------------------------------------
module bss_cell (
   input  logic                         clock,
   input  bss_pkg::cell_ctl_type        ctl,
   input  logic [bss_pkg::SAMPLE_W-1:0] sample_in,
   input  logic                         prev_gt,
   input  logic [bss_pkg::SAMPLE_W-1:0] prev_value,
   input  logic [bss_pkg::SAMPLE_W-1:0] next_read,
   output logic                         gt,
   output logic [bss_pkg::SAMPLE_W-1:0] value,
   output logic [bss_pkg::SAMPLE_W-1:0] read_value
);
   import bss_pkg::*;

   logic [SAMPLE_W-1:0] store_ff, store_in;
   logic [SAMPLE_W-1:0] read_ff, read_in;

   assign gt         = ctl.occupied && (store_ff > sample_in);
   assign value      = store_ff;
   assign read_value = read_ff;

   always_comb begin
      store_in = store_ff;
      if (ctl.insert && (ctl.occupied || ctl.tail)) begin
         if (prev_gt) begin
            store_in = prev_value;
         end else if (gt || ctl.tail) begin
            store_in = sample_in;
         end
      end
      read_in = read_ff;
      if (ctl.load) begin
         read_in = store_ff;
      end else if (ctl.shift) begin
         read_in = next_read;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      read_ff  <= read_in;
   end

endmodule

// ===== sv/bss_divider.sv =====
// ----------------------------------------------------------------------------
// bss_divider
// Restoring divider, two quotient bits per cycle. The quotient must fit
// SAMPLE_W bits, so the dividend's top CNT_W bits lie below the divisor.
// ----------------------------------------------------------------------------
module bss_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bss_pkg::SUM_W-1:0]    dividend,
   input  logic [bss_pkg::CNT_W-1:0]    divisor,
   output logic                         done,
   output logic [bss_pkg::SAMPLE_W-1:0] quotient
);
   import bss_pkg::*;

   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     dsr_ff, dsr_in;
   logic [SAMPLE_W-1:0]  quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W:0]       first, second;

   function automatic logic [CNT_W:0] div_bit(input logic [CNT_W-1:0] rem,
                                               input logic b,
                                               input logic [CNT_W-1:0] d);
      logic [CNT_W:0] t;
      logic [CNT_W:0] r;
      t = {rem, b};
      r = t - {1'b0, d};
      if (t >= {1'b0, d}) begin
         div_bit = {1'b1, r[CNT_W-1:0]};
      end else begin
         div_bit = {1'b0, t[CNT_W-1:0]};
      end
   endfunction

   assign first    = div_bit(rem_ff, quo_ff[SAMPLE_W-1], dsr_ff);
   assign second   = div_bit(first[CNT_W-1:0], quo_ff[SAMPLE_W-2], dsr_ff);
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[SUM_W-1 -: CNT_W];
         quo_in  = dividend[SAMPLE_W-1:0];
         dsr_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = second[CNT_W-1:0];
         quo_in  = {quo_ff[SAMPLE_W-3:0], first[CNT_W], second[CNT_W]};
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

endmodule

// ===== sv/batch_sample_statistics.sv =====
// ----------------------------------------------------------------------------
// batch_sample_statistics
// Sorted sample batch with median, mean, trimmed mean, minimum and maximum.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall carry one 16-bit sample per transaction; a sample
//   inside [accept_low, accept_high] is inserted into the sorted batch, and
//   a full batch restarts with it. rsp_valid/rsp_stall return one result per
//   transaction describing the batch after that sample.
//   csr_write/csr_index/csr_wdata set the window and batch length; write
//   only while no transaction is in flight.
//   A sample is inserted into the row of cells as it is accepted. The row
//   is then read out through its shift chain, one cell a cycle, and one
//   shared two-bit per cycle divider computes the mean and, with three or
//   more samples, the trimmed mean; an empty batch skips both. The result
//   goes into the output register, after which the block is idle and
//   takes the next sample. The output register holds a result while the
//   next sample is taken; if rsp_stall is still high when the next result
//   is ready, the block waits and holds req_stall high.
//   Reset restores the register defaults and empties the batch.
// ----------------------------------------------------------------------------
module batch_sample_statistics #(
   parameter int STORE_DEPTH = bss_pkg::STORE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bss_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_accepted,
   output logic                           rsp_wants_more,
   output logic [bss_pkg::CNT_W-1:0]      rsp_count,
   output logic [bss_pkg::SAMPLE_W-1:0]   rsp_median,
   output logic [bss_pkg::SAMPLE_W-1:0]   rsp_mean,
   output logic [bss_pkg::SAMPLE_W-1:0]   rsp_trimmed_mean,
   output logic [bss_pkg::SAMPLE_W-1:0]   rsp_minimum,
   output logic [bss_pkg::SAMPLE_W-1:0]   rsp_maximum,
   input  logic                           csr_write,
   input  logic [bss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bss_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bss_pkg::*;

   state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] low_ff, high_ff;
   logic [CNT_W-1:0]    blen_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                acc_ff, acc_in;
   logic                more_ff, more_in;
   logic [SAMPLE_W-1:0] min_ff, min_in, med_ff, med_in, max_ff, max_in;
   logic [SAMPLE_W-1:0] mean_ff, mean_in, tmean_ff, tmean_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_acc_ff, rsp_more_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic [SAMPLE_W-1:0] rsp_med_ff, rsp_mean_ff, rsp_tmean_ff, rsp_min_ff, rsp_max_ff;
   logic                out_load;

   logic                req_accept, in_window, do_insert;
   logic [CNT_W-1:0]    len_raw, len, count_eff, count_next;
   logic [CNT_W-1:0]    last_idx, mid_idx;
   logic [SAMPLE_W-1:0] head;
   logic                cell_load, cell_shift;

   logic                div_start, div_done;
   logic [SUM_W-1:0]    div_dividend;
   logic [CNT_W-1:0]    div_divisor;
   logic [SAMPLE_W-1:0] div_quotient;

   logic                gt_w   [STORE_DEPTH];
   logic [SAMPLE_W-1:0] val_w  [STORE_DEPTH];
   logic [SAMPLE_W-1:0] rd_w   [STORE_DEPTH];

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign len_raw   = (blen_ff == '0) ? CNT_W'(1) : blen_ff;
   assign len       = (int'(len_raw) > STORE_DEPTH) ? CNT_W'(STORE_DEPTH) : len_raw;
   assign count_eff = (count_ff >= len) ? '0 : count_ff;
   assign in_window = (req_sample >= low_ff) && (req_sample <= high_ff);
   assign do_insert = req_accept && in_window;
   assign count_next = count_eff + 1'b1;

   assign last_idx = count_ff - 1'b1;
   assign mid_idx  = last_idx >> 1;
   assign head     = rd_w[0];

   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      cell_ctl_type        ctl;
      logic                prev_gt;
      logic [SAMPLE_W-1:0] prev_value, next_read;

      assign ctl = {do_insert, cell_load, cell_shift,
                    (int'(count_eff) > i), (int'(count_eff) == i)};

      if (i == 0) begin : g_head
         assign prev_gt    = 1'b0;
         assign prev_value = '0;
      end else begin : g_body
         assign prev_gt    = gt_w[i-1];
         assign prev_value = val_w[i-1];
      end

      if (i == STORE_DEPTH - 1) begin : g_end
         assign next_read = '0;
      end else begin : g_link
         assign next_read = rd_w[i+1];
      end

      bss_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .sample_in  (req_sample),
         .prev_gt    (prev_gt),
         .prev_value (prev_value),
         .next_read  (next_read),
         .gt         (gt_w[i]),
         .value      (val_w[i]),
         .read_value (rd_w[i])
      );
   end

   bss_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      more_in      = more_ff;
      min_in       = min_ff;
      med_in       = med_ff;
      max_in       = max_ff;
      mean_in      = mean_ff;
      tmean_in     = tmean_ff;
      cell_load    = 1'b0;
      cell_shift   = 1'b0;
      div_start    = 1'b0;
      div_dividend = sum_ff + SUM_W'(count_ff >> 1);
      div_divisor  = count_ff;
      out_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               acc_in   = in_window;
               more_in  = in_window ? (count_next < len) : 1'b1;
               min_in   = '0;
               med_in   = '0;
               max_in   = '0;
               mean_in  = '0;
               tmean_in = '0;
               if (in_window) begin
                  count_in = count_next;
                  sum_in   = ((count_ff >= len) ? '0 : sum_ff) + SUM_W'(req_sample);
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cell_load = 1'b1;
            idx_in    = '0;
            state_in  = (count_ff == '0) ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            cell_shift = 1'b1;
            idx_in     = idx_ff + 1'b1;
            if (idx_ff == '0) begin
               min_in = head;
            end
            if (idx_ff == mid_idx) begin
               med_in = head;
            end
            if (idx_ff == last_idx) begin
               max_in    = head;
               div_start = 1'b1;
               state_in  = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            if (div_done) begin
               mean_in = div_quotient;
               if (count_ff >= CNT_W'(3)) begin
                  div_start    = 1'b1;
                  div_dividend = sum_ff - SUM_W'(min_ff) - SUM_W'(max_ff)
                                 + SUM_W'((count_ff - CNT_W'(2)) >> 1);
                  div_divisor  = count_ff - CNT_W'(2);
                  state_in     = ST_DIV_TRIM;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV_TRIM: begin
            if (div_done) begin
               tmean_in = div_quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         low_ff       <= ACCEPT_LOW_RST;
         high_ff      <= ACCEPT_HIGH_RST;
         blen_ff      <= BATCH_LEN_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_ACCEPT_LOW:  low_ff  <= csr_wdata[SAMPLE_W-1:0];
               CSR_ACCEPT_HIGH: high_ff <= csr_wdata[SAMPLE_W-1:0];
               CSR_BATCH_LEN:   blen_ff <= csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      acc_ff   <= acc_in;
      more_ff  <= more_in;
      min_ff   <= min_in;
      med_ff   <= med_in;
      max_ff   <= max_in;
      mean_ff  <= mean_in;
      tmean_ff <= tmean_in;
      if (out_load) begin
         rsp_acc_ff   <= acc_ff;
         rsp_more_ff  <= more_ff;
         rsp_count_ff <= count_ff;
         rsp_med_ff   <= med_ff;
         rsp_mean_ff  <= mean_ff;
         rsp_tmean_ff <= tmean_ff;
         rsp_min_ff   <= min_ff;
         rsp_max_ff   <= max_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_acc_ff;
   assign rsp_wants_more   = rsp_more_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_median       = rsp_med_ff;
   assign rsp_mean         = rsp_mean_ff;
   assign rsp_trimmed_mean = rsp_tmean_ff;
   assign rsp_minimum      = rsp_min_ff;
   assign rsp_maximum      = rsp_max_ff;

endmodule

// ===== sv/bss_checker.sv =====
// ----------------------------------------------------------------------------
// bss_checker
// Port-level checks on the result channel of batch_sample_statistics.
// ----------------------------------------------------------------------------
`include "batch_sample_statistics_defines.svh"

module bss_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_accepted,
   input logic                           rsp_wants_more,
   input logic [bss_pkg::CNT_W-1:0]      rsp_count,
   input logic [bss_pkg::SAMPLE_W-1:0]   rsp_median,
   input logic [bss_pkg::SAMPLE_W-1:0]   rsp_mean,
   input logic [bss_pkg::SAMPLE_W-1:0]   rsp_trimmed_mean,
   input logic [bss_pkg::SAMPLE_W-1:0]   rsp_minimum,
   input logic [bss_pkg::SAMPLE_W-1:0]   rsp_maximum
);

   `BSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_count) && $stable(rsp_median) && $stable(rsp_mean) && $stable(rsp_maximum), "stalled result changed")

   `BSS_ASSERT_SAME(a_stored_nonempty, rsp_valid && rsp_accepted, rsp_count != 0, "stored sample but empty batch")

   `BSS_ASSERT_SAME(a_reject_wants, rsp_valid && !rsp_accepted, rsp_wants_more, "rejected sample must want more")

   `BSS_ASSERT_SAME(a_order, rsp_valid && rsp_count != 0, rsp_minimum <= rsp_median && rsp_median <= rsp_maximum && rsp_minimum <= rsp_mean && rsp_mean <= rsp_maximum, "statistics out of order")

   `BSS_ASSERT_SAME(a_empty_zero, rsp_valid && rsp_count == 0, rsp_median == 0 && rsp_mean == 0 && rsp_trimmed_mean == 0 && rsp_minimum == 0 && rsp_maximum == 0, "empty batch must report zeros")

endmodule

bind batch_sample_statistics bss_checker u_bss_checker (.*);
